### src/haar_2d_analysis_one_level_top_defines.svh
// assertion macros shared by the haar 2d analysis rtl
// no dependencies; expects clk and rst in the scope of each use
`ifndef HAAR_2D_ANALYSIS_ONE_LEVEL_TOP_DEFINES_SVH
`define HAAR_2D_ANALYSIS_ONE_LEVEL_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold at every clock outside reset
`define HAAR2D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("haar2d assertion failed");

// condition that must never be seen outside reset
`define HAAR2D_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("haar2d forbidden condition seen");

`else

`define HAAR2D_ASSERT(lbl, prop)
`define HAAR2D_NEVER(lbl, cond)

`endif

`endif

### src/haar2d_pkg.sv
// types, constants and arithmetic helpers for the haar 2d analysis block
// no dependencies
package haar2d_pkg;

  // default size limits and queue depth
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int QUEUE_DEPTH    = 4;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(1024);
  localparam logic [CFG_W-1:0] SIZE_MIN   = CFG_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // band index width on the result port
  localparam int BIDX_W = 9;

  // one row-pass pair as handed from front to back
  typedef struct packed {
    logic              odd_row;
    logic [7:0]        lo;
    logic [7:0]        hi;
    logic [BIDX_W-1:0] brow;
    logic [BIDX_W-1:0] bcol;
    logic              last;
  } pair_t;

  // (x + y) / 2
  function automatic logic [7:0] avg2(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[8:1];
  endfunction

  // (x - y) / 2 rounded toward zero, plus 128
  function automatic logic [7:0] half_diff(input logic [7:0] x, input logic [7:0] y);
    logic signed [8:0] d;
    logic signed [8:0] h;
    logic signed [8:0] r;
    d = $signed({1'b0, x}) - $signed({1'b0, y});
    h = (d + $signed({8'd0, d[8]})) >>> 1;
    r = h + 9'sd128;
    return r[7:0];
  endfunction

endpackage

### src/haar2d_front.sv
// front end: size registers, raster counters and the row pass
// depends on haar2d_pkg
module haar2d_front import haar2d_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int AW         = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           pixel,
  input  logic                 q_full,
  output logic                 push,
  output logic [AW-1:0]        push_addr,
  output pair_t                push_pair
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int WCW = (WW > CFG_W) ? WW : CFG_W;
  localparam int HCW = (HW > CFG_W) ? HW : CFG_W;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CW-1:0]    column_count;
  logic [RW-1:0]    row_count;
  logic [7:0]       pending;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] col0;
  logic [RW-1:0] row0;
  logic [WW-1:0] col1;
  logic [HW-1:0] row1;
  logic [CW-1:0] column_count_next;
  logic [RW-1:0] row_count_next;
  logic          accept;
  logic          last_col;
  logic          last_row;

  // clamp the programmed size into the supported range
  always_comb begin
    if (image_width < SIZE_MIN) begin
      w_eff = WW'(2);
    end else if (WCW'(image_width) > WCW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height < SIZE_MIN) begin
      h_eff = HW'(2);
    end else if (HCW'(image_height) > HCW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(image_height);
    end
  end

  // position of this pixel, with wrap after a size change
  always_comb begin
    col0 = (WW'(column_count) >= w_eff) ? '0 : column_count;
    row0 = (HW'(row_count) >= h_eff) ? '0 : row_count;
    col1 = WW'(col0) + WW'(1);
    row1 = HW'(row0) + HW'(1);
    if (col1 >= w_eff) begin
      column_count_next = '0;
      row_count_next    = (row1 >= h_eff) ? '0 : RW'(row1);
    end else begin
      column_count_next = CW'(col1);
      row_count_next    = row0;
    end
  end

  // last block of the frame
  assign last_col = (WW'(col0 >> 1) == (w_eff >> 1) - WW'(1));
  assign last_row = (HW'(row0 >> 1) == (h_eff >> 1) - HW'(1));

  // handshake: hold off only when the queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // row pass of the current pair
  assign push              = accept && col0[0];
  assign push_addr         = AW'(col0 >> 1);
  assign push_pair.odd_row = row0[0];
  assign push_pair.lo      = avg2(pending, pixel);
  assign push_pair.hi      = half_diff(pending, pixel);
  assign push_pair.brow    = BIDX_W'(row0 >> 1);
  assign push_pair.bcol    = BIDX_W'(col0 >> 1);
  assign push_pair.last    = last_col && last_row;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
      endcase
    end
  end

  // raster counters and left pixel of the pair
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      pending      <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      if (!col0[0]) begin
        pending <= pixel;
      end
    end
  end

endmodule

### src/haar2d_queue.sv
// short queue of row-pass pairs between front and back
// depends on haar2d_pkg and the assertion macro header
`include "haar_2d_analysis_one_level_top_defines.svh"
module haar2d_queue import haar2d_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign full  = (count == NW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  `HAAR2D_NEVER(a_queue_overflow, push && full && !pop)
  `HAAR2D_NEVER(a_queue_underflow, pop && !valid)
  `HAAR2D_ASSERT(a_queue_level, (push && !pop) |=> (count == $past(count) + NW'(1)))

endmodule

### src/haar2d_back.sv
// back end: line store, column pass and the result register
// depends on haar2d_pkg and the assertion macro header
`include "haar_2d_analysis_one_level_top_defines.svh"
module haar2d_back import haar2d_pkg::*; #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  logic [AW-1:0]     q_addr,
  input  pair_t             q_pair,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        band_ll,
  output logic [7:0]        band_lh,
  output logic [7:0]        band_hl,
  output logic [7:0]        band_hh,
  output logic [BIDX_W-1:0] block_row,
  output logic [BIDX_W-1:0] block_col,
  output logic              frame_last
);

  // line store holds {low, high} of the even row
  logic [15:0] line_store [DEPTH];
  logic [15:0] even_rd;

  logic  a_valid;
  pair_t a_pair;
  logic  out_free;
  logic  a_adv;
  logic  q_read;

  assign out_free = !out_valid || !out_stall;
  assign a_adv    = a_valid && out_free;
  assign q_pop    = q_valid && (!q_pair.odd_row || !a_valid || a_adv);
  assign q_read   = q_pop && q_pair.odd_row;

  // store write on even rows, registered read on odd rows
  always_ff @(posedge clk) begin
    if (q_pop && !q_pair.odd_row) begin
      line_store[q_addr] <= {q_pair.lo, q_pair.hi};
    end
    if (q_read) begin
      even_rd <= line_store[q_addr];
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (q_read) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_read) begin
      a_pair <= q_pair;
    end
  end

  // column pass into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      band_ll    <= avg2(even_rd[15:8], a_pair.lo);
      band_lh    <= half_diff(even_rd[15:8], a_pair.lo);
      band_hl    <= avg2(even_rd[7:0], a_pair.hi);
      band_hh    <= half_diff(even_rd[7:0], a_pair.hi);
      block_row  <= a_pair.brow;
      block_col  <= a_pair.bcol;
      frame_last <= a_pair.last;
    end
  end

  `HAAR2D_ASSERT(a_read_stage_holds, (a_valid && !out_free) |=> a_valid)
  `HAAR2D_NEVER(a_read_stage_clobber, q_read && a_valid && !a_adv)

endmodule

### src/haar_2d_analysis_one_level_top.sv
// top level of the one-level 2d haar analysis
// depends on haar2d_pkg, haar2d_front, haar2d_queue and haar2d_back
//
// Takes one 8-bit pixel per clock in raster order when not stalled and gives
// one result per 2x2 block, carrying the LL, LH, HL and HH bands with the
// block position and a last-of-frame flag. The front end takes a pixel every
// cycle while its four-entry pair queue has room; the back end drains one pair
// per cycle through a single-port line store of MAX_WIDTH/2 entries unless the
// result register is stalled, so the sustained rate is one pixel per clock. A
// result passes the pair queue, the read stage and the result register after
// the second pixel of its odd-row pair is taken, later when the output stalls.
// The line store is not cleared: after a width change mid-frame the first odd
// row may read stale entries. Size registers should be written while no pixel
// is in flight; odd last rows and columns are dropped.
module haar_2d_analysis_one_level_top import haar2d_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           band_ll,
  output logic [7:0]           band_lh,
  output logic [7:0]           band_hl,
  output logic [7:0]           band_hh,
  output logic [BIDX_W-1:0]    block_row,
  output logic [BIDX_W-1:0]    block_col,
  output logic                 frame_last
);

  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int QW          = AW + $bits(pair_t);

  logic          push;
  logic [AW-1:0] push_addr;
  pair_t         push_pair;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic [QW-1:0] q_dout;
  logic [AW-1:0] q_addr;
  pair_t         q_pair;

  // pixel intake and row pass
  haar2d_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel     (pixel),
    .q_full    (q_full),
    .push      (push),
    .push_addr (push_addr),
    .push_pair (push_pair)
  );

  // pair queue
  haar2d_queue #(
    .DEPTH (QUEUE_DEPTH),
    .DW    (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({push_addr, push_pair}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  assign q_addr = q_dout[QW-1 -: AW];
  assign q_pair = pair_t'(q_dout[$bits(pair_t)-1:0]);

  // line store and column pass
  haar2d_back #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_addr     (q_addr),
    .q_pair     (q_pair),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .band_ll    (band_ll),
    .band_lh    (band_lh),
    .band_hl    (band_hl),
    .band_hh    (band_hh),
    .block_row  (block_row),
    .block_col  (block_col),
    .frame_last (frame_last)
  );

endmodule
